### rtl/core/wpd_pkg.sv
// wpd_pkg: shared types and constants for the window peak detector
// item structs, register indexes and reset values; no dependencies
`timescale 1ns / 1ps

package wpd_pkg;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_INDEX_W = 1;
	localparam int PEAK_CNT_W = 11;
	localparam int ORDINAL_W = 10;
	localparam int OUT_INDEX_W = 16;
	localparam int BIN_COUNT_W = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_PEAK_THRESHOLD = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_PEAKS = 1'b1;

	localparam logic [15:0] THRESHOLD_RESET = 16'd50;
	localparam logic [PEAK_CNT_W-1:0] MAX_PEAKS_RESET = 11'd50;
	localparam logic [PEAK_CNT_W-1:0] ORDINAL_LIMIT = 11'd1024;

	typedef struct packed {
		logic [BIN_COUNT_W-1:0] bin_count;
		logic is_last;
	} bin_item_t;

	typedef struct packed {
		logic [OUT_INDEX_W-1:0] peak_index;
		logic [ORDINAL_W-1:0] peak_ordinal;
	} peak_item_t;

	typedef struct packed {
		logic hit;
		logic take;
		peak_item_t item;
	} peak_res_t;

endpackage

### rtl/core/wpd_window.sv
// wpd_window: shift line of past bin counts and the centre-is-maximum test
// uses wpd_pkg for the input width
`timescale 1ns / 1ps

module wpd_window #(
	parameter int HALF_WINDOW = 10,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   shift_en,
	input  logic [wpd_pkg::BIN_COUNT_W-1:0] bin_count,
	output logic                   centre_max,
	output logic [COUNT_WIDTH-1:0] centre_val
);

	localparam int TAPS = 2 * HALF_WINDOW;

	logic [COUNT_WIDTH-1:0] taps_q [TAPS];
	logic [COUNT_WIDTH+wpd_pkg::BIN_COUNT_W-1:0] count_ext;
	logic [COUNT_WIDTH-1:0] count;
	logic [TAPS:0] ge;

	assign count_ext = {{COUNT_WIDTH{1'b0}}, bin_count};
	assign count = count_ext[COUNT_WIDTH-1:0];
	assign centre_val = taps_q[HALF_WINDOW-1];

	always_ff @(posedge clk) begin
		if (shift_en) begin
			taps_q[0] <= count;
			for (int j = 1; j < TAPS; j++) begin
				taps_q[j] <= taps_q[j-1];
			end
		end
	end

	// centre against the new sample and every other tap
	always_comb begin
		ge[TAPS] = (centre_val >= count);
		for (int j = 0; j < TAPS; j++) begin
			ge[j] = (j == HALF_WINDOW - 1) ? 1'b1 : (centre_val >= taps_q[j]);
		end
	end

	assign centre_max = &ge;

endmodule

### rtl/core/wpd_counter.sv
// wpd_counter: sample and peak counters and the peak decision
// uses wpd_pkg for the result struct and the ordinal limit
`timescale 1ns / 1ps

module wpd_counter #(
	parameter int HALF_WINDOW = 10,
	parameter int COUNT_WIDTH = 16,
	parameter int INDEX_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic                   is_last,
	input  logic                   centre_max,
	input  logic [COUNT_WIDTH-1:0] centre_val,
	input  logic [15:0]            peak_threshold,
	input  logic [wpd_pkg::PEAK_CNT_W-1:0] max_peaks,
	output wpd_pkg::peak_res_t     res
);

	logic [INDEX_WIDTH-1:0] sample_cnt_q;
	logic [wpd_pkg::PEAK_CNT_W-1:0] peak_cnt_q;
	logic [wpd_pkg::PEAK_CNT_W-1:0] limit;
	logic [INDEX_WIDTH-1:0] centre;
	logic [INDEX_WIDTH+wpd_pkg::OUT_INDEX_W-1:0] centre_ext;
	logic [COUNT_WIDTH+15:0] val_ext;
	logic [COUNT_WIDTH+15:0] thr_ext;
	logic tested;

	assign limit = (max_peaks > wpd_pkg::ORDINAL_LIMIT) ? wpd_pkg::ORDINAL_LIMIT : max_peaks;
	assign centre = sample_cnt_q - INDEX_WIDTH'(HALF_WINDOW);
	assign centre_ext = {{wpd_pkg::OUT_INDEX_W{1'b0}}, centre};
	assign val_ext = {16'b0, centre_val};
	assign thr_ext = {{COUNT_WIDTH{1'b0}}, peak_threshold};
	assign tested = sample_cnt_q >= INDEX_WIDTH'(2 * HALF_WINDOW);

	always_comb begin
		res.take = (sample_cnt_q != {INDEX_WIDTH{1'b1}});
		res.hit = res.take && tested && centre_max && (val_ext >= thr_ext)
			&& (peak_cnt_q < limit);
		res.item.peak_index = centre_ext[wpd_pkg::OUT_INDEX_W-1:0];
		res.item.peak_ordinal = peak_cnt_q[wpd_pkg::ORDINAL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_cnt_q <= '0;
			peak_cnt_q <= '0;
		end else if (step) begin
			if (is_last) begin
				sample_cnt_q <= '0;
				peak_cnt_q <= '0;
			end else begin
				if (res.take) begin
					sample_cnt_q <= sample_cnt_q + 1'b1;
				end
				if (res.hit) begin
					peak_cnt_q <= peak_cnt_q + 1'b1;
				end
			end
		end
	end

endmodule

### rtl/core/window_peak_detector.sv
// window_peak_detector: top level, input register, configuration and result register
// uses wpd_pkg, wpd_window and wpd_counter
// a peak passes the input register and then the result register before it appears on peak_valid
// throughput: one bin item per cycle; held only while a stalled result waits
// reset: counters cleared, peak_threshold and max_peaks return to 50,
//   window contents stay undefined and are read only once refilled
`timescale 1ns / 1ps

module window_peak_detector #(
	parameter int HALF_WINDOW = 10,
	parameter int COUNT_WIDTH = 16,
	parameter int INDEX_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 bin_valid,
	output logic                 bin_stall,
	input  wpd_pkg::bin_item_t   bin_item,
	output logic                 peak_valid,
	input  logic                 peak_stall,
	output wpd_pkg::peak_item_t  peak_item,
	input  logic                 cfg_write,
	input  logic [wpd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [wpd_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic valid_s1;
	wpd_pkg::bin_item_t item_s1;
	logic out_valid_q;
	wpd_pkg::peak_item_t out_item_q;
	logic [15:0] threshold_q;
	logic [wpd_pkg::PEAK_CNT_W-1:0] max_peaks_q;
	logic advance;
	logic step;
	logic centre_max;
	logic [COUNT_WIDTH-1:0] centre_val;
	wpd_pkg::peak_res_t res;

	assign advance = !out_valid_q || !peak_stall;
	assign bin_stall = valid_s1 && !advance;
	assign step = valid_s1 && advance;
	assign peak_valid = out_valid_q;
	assign peak_item = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= wpd_pkg::THRESHOLD_RESET;
			max_peaks_q <= wpd_pkg::MAX_PEAKS_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				wpd_pkg::REG_PEAK_THRESHOLD: threshold_q <= cfg_data;
				wpd_pkg::REG_MAX_PEAKS: max_peaks_q <= cfg_data[wpd_pkg::PEAK_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!bin_stall) begin
			valid_s1 <= bin_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!bin_stall && bin_valid) begin
			item_s1 <= bin_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.hit) begin
			out_item_q <= res.item;
		end
	end

	wpd_window #(
		.HALF_WINDOW(HALF_WINDOW),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_window (
		.clk        (clk),
		.shift_en   (step && res.take),
		.bin_count  (item_s1.bin_count),
		.centre_max (centre_max),
		.centre_val (centre_val)
	);

	wpd_counter #(
		.HALF_WINDOW(HALF_WINDOW),
		.COUNT_WIDTH(COUNT_WIDTH),
		.INDEX_WIDTH(INDEX_WIDTH)
	) u_counter (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.is_last        (item_s1.is_last),
		.centre_max     (centre_max),
		.centre_val     (centre_val),
		.peak_threshold (threshold_q),
		.max_peaks      (max_peaks_q),
		.res            (res)
	);

endmodule

### tb/tb_window_peak_detector.sv
// tb_window_peak_detector: self-checking bench for the window peak detector
// drives bin items with random gaps and stalls, predicts peaks and checks each one
// depends on wpd_pkg and window_peak_detector
`timescale 1ns / 1ps

module tb_window_peak_detector;

	localparam int HALF_WIN = 10;
	localparam int WIN_LEN = 2 * HALF_WIN + 1;
	localparam int DRAIN_CYCLES = 4;
	localparam logic [15:0] SAMPLE_FULL = 16'hFFFF;

	logic clk;
	logic arst_n;
	logic bin_valid;
	logic bin_stall;
	wpd_pkg::bin_item_t bin_item;
	logic peak_valid;
	logic peak_stall;
	wpd_pkg::peak_item_t peak_item;
	logic cfg_write;
	logic [wpd_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [wpd_pkg::CFG_DATA_W-1:0] cfg_data;

	// predicted block state
	logic [15:0] win_copy [WIN_LEN];
	logic [15:0] samples_in_hist;
	logic [10:0] peaks_in_hist;
	logic [15:0] cur_threshold;
	logic [10:0] cur_max_peaks;

	wpd_pkg::peak_item_t peak_expect [$];
	bit idle_on;
	int err_count;
	int peaks_seen;
	int bins_sent;
	int hists_sent;

	window_peak_detector u_top (
		.clk(clk),
		.arst_n(arst_n),
		.bin_valid(bin_valid),
		.bin_stall(bin_stall),
		.bin_item(bin_item),
		.peak_valid(peak_valid),
		.peak_stall(peak_stall),
		.peak_item(peak_item),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("timeout with %0d peaks outstanding", peak_expect.size());
		$display("tb_window_peak_detector: errors");
		$finish;
	end

	task automatic flag_error(input string msg);
		$display("mismatch: %s", msg);
		err_count++;
	endtask

	task automatic predict_bin(input wpd_pkg::bin_item_t it);
		logic [15:0] top;
		logic [15:0] centre;
		logic [15:0] centre_val;
		logic [10:0] limit;
		wpd_pkg::peak_item_t pk;
		if (samples_in_hist != SAMPLE_FULL) begin
			win_copy[samples_in_hist % WIN_LEN] = it.bin_count;
			if (samples_in_hist >= 2 * HALF_WIN) begin
				centre = samples_in_hist - 16'(HALF_WIN);
				centre_val = win_copy[centre % WIN_LEN];
				top = '0;
				for (int i = 0; i < WIN_LEN; i++) begin
					if (win_copy[i] > top) top = win_copy[i];
				end
				limit = (cur_max_peaks > wpd_pkg::ORDINAL_LIMIT) ? wpd_pkg::ORDINAL_LIMIT
					: cur_max_peaks;
				if (centre_val == top && top >= cur_threshold && peaks_in_hist < limit) begin
					pk.peak_index = centre;
					pk.peak_ordinal = peaks_in_hist[wpd_pkg::ORDINAL_W-1:0];
					peak_expect.push_back(pk);
					peaks_in_hist = peaks_in_hist + 11'd1;
				end
			end
			samples_in_hist = samples_in_hist + 16'd1;
		end
		if (it.is_last) begin
			samples_in_hist = '0;
			peaks_in_hist = '0;
		end
	endtask

	task automatic send_bin(input logic [15:0] count, input logic last);
		wpd_pkg::bin_item_t it;
		it.bin_count = count;
		it.is_last = last;
		while (idle_on && $urandom_range(99) < 23) begin
			bin_valid <= 1'b0;
			@(posedge clk);
		end
		bin_valid <= 1'b1;
		bin_item <= it;
		@(posedge clk);
		while (bin_stall) @(posedge clk);
		predict_bin(it);
		bins_sent++;
		if (last) hists_sent++;
	endtask

	// both registers are written back to back once the pipeline has drained
	task automatic load_config(input logic [15:0] thr, input logic [10:0] maxp);
		bin_valid <= 1'b0;
		while (peak_expect.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= wpd_pkg::REG_PEAK_THRESHOLD;
		cfg_data <= thr;
		@(posedge clk);
		cfg_index <= wpd_pkg::REG_MAX_PEAKS;
		cfg_data <= {5'($urandom_range(31)), maxp};
		@(posedge clk);
		cfg_write <= 1'b0;
		cur_threshold = thr;
		cur_max_peaks = maxp;
	endtask

	task automatic test_directed();
		logic [15:0] c;
		for (int i = 0; i < 23; i++) begin
			case (i)
				0, 10, 11, 22: c = 16'hFFFF;
				12: c = 16'd49;
				15: c = 16'd50;
				default: c = 16'd0;
			endcase
			send_bin(c, i == 22);
		end
		send_bin(16'hFFFF, 1'b0);
		send_bin(16'd0, 1'b1);
	endtask

	task automatic test_threshold_extremes();
		load_config(16'd0, 11'd50);
		for (int i = 0; i < 25; i++) send_bin(16'd0, i == 24);
		load_config(16'hFFFF, 11'd50);
		for (int i = 0; i < 24; i++) begin
			send_bin((i == 10) ? 16'hFFFE : (i == 12) ? 16'hFFFF : 16'($urandom_range(1000)),
				i == 23);
		end
	endtask

	task automatic test_peak_limit();
		load_config(16'd50, 11'd0);
		for (int i = 0; i < 30; i++) send_bin(16'd100, i == 29);
		load_config(16'd50, 11'd3);
		for (int i = 0; i < 30; i++) send_bin(16'd100, i == 29);
		// settings at and above the ordinal limit
		load_config(16'd0, 11'd1024);
		for (int i = 0; i < 40; i++) send_bin(16'd777, i == 39);
		load_config(16'd0, 11'd2047);
		for (int i = 0; i < 40; i++) send_bin(16'hFFFF, i == 39);
	endtask

	task automatic test_random_streams();
		int n_items;
		int len;
		int mode;
		int base;
		int h;
		logic [15:0] thr;
		logic [10:0] maxp;
		logic [15:0] c;
		n_items = 0;
		h = 0;
		while (n_items < 600) begin
			if (h % 8 == 0) begin
				case ($urandom_range(9))
					0: thr = 16'd0;
					1: thr = 16'hFFFF;
					2, 3: thr = 16'($urandom_range(65535));
					default: thr = 16'($urandom_range(3000));
				endcase
				case ($urandom_range(7))
					0: maxp = 11'd0;
					1: maxp = 11'd1024;
					2: maxp = 11'd2047;
					3: maxp = 11'($urandom_range(2047));
					4, 5: maxp = 11'($urandom_range(1, 8));
					default: maxp = 11'd50;
				endcase
				load_config(thr, maxp);
			end
			// a long stretch with neither side idling
			idle_on = !(h >= 4 && h < 10);
			len = ($urandom_range(99) < 15) ? $urandom_range(1, 20) : $urandom_range(21, 70);
			mode = $urandom_range(2);
			base = $urandom_range(65532);
			for (int i = 0; i < len; i++) begin
				case (mode)
					0: c = 16'($urandom_range(65535));
					1: c = 16'(base + $urandom_range(3));
					default: c = ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
						: 16'($urandom_range(100));
				endcase
				send_bin(c, i == len - 1);
			end
			n_items += len;
			h++;
		end
		idle_on = 1'b1;
	endtask

	// peak checker
	initial begin
		wpd_pkg::peak_item_t want;
		forever begin
			@(posedge clk);
			if (arst_n && peak_valid && !peak_stall) begin
				peaks_seen++;
				if (peak_expect.size() == 0) begin
					flag_error($sformatf("unexpected peak index %0d ordinal %0d",
						peak_item.peak_index, peak_item.peak_ordinal));
				end else begin
					want = peak_expect.pop_front();
					if (peak_item.peak_index !== want.peak_index)
						flag_error($sformatf("peak_index %0d, wanted %0d",
							peak_item.peak_index, want.peak_index));
					if (peak_item.peak_ordinal !== want.peak_ordinal)
						flag_error($sformatf("peak_ordinal %0d, wanted %0d at index %0d",
							peak_item.peak_ordinal, want.peak_ordinal, want.peak_index));
				end
			end
		end
	end

	// receiver stalls
	initial begin
		peak_stall <= 1'b0;
		forever begin
			@(posedge clk);
			peak_stall <= idle_on && ($urandom_range(99) < 23);
		end
	end

	initial begin
		arst_n <= 1'b0;
		bin_valid <= 1'b0;
		bin_item <= '0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		idle_on = 1'b1;
		err_count = 0;
		peaks_seen = 0;
		bins_sent = 0;
		hists_sent = 0;
		samples_in_hist = '0;
		peaks_in_hist = '0;
		cur_threshold = wpd_pkg::THRESHOLD_RESET;
		cur_max_peaks = wpd_pkg::MAX_PEAKS_RESET;
		for (int i = 0; i < WIN_LEN; i++) win_copy[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_threshold_extremes();
		test_peak_limit();
		test_random_streams();

		bin_valid <= 1'b0;
		while (peak_expect.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES * 4) @(posedge clk);

		$display("%0d bin items in %0d histograms, %0d peaks checked", bins_sent, hists_sent,
			peaks_seen);
		$display("covered plateaus, threshold and peak limits, random gaps and stalls");
		if (err_count == 0) begin
			$display("tb_window_peak_detector: clean");
		end else begin
			$display("tb_window_peak_detector: errors");
		end
		$finish;
	end

endmodule
